// ===== rtl/two_key_chained_hash_map_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the two-key chained hash map
// Concurrent checks that compile away in synthesis.
// ---------------------------------------------------------------------------
`ifndef TWO_KEY_CHAINED_HASH_MAP_DEFINES_SVH
`define TWO_KEY_CHAINED_HASH_MAP_DEFINES_SVH

`ifndef SYNTHESIS
`define TKCHM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TKCHM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TKCHM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TKCHM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/tkchm_pkg.sv =====
// ---------------------------------------------------------------------------
// tkchm_pkg
// Types and constants shared by the two-key chained hash map.
// ---------------------------------------------------------------------------
package tkchm_pkg;

    localparam int BUCKETS = 1024;
    localparam int ENTRIES = 256;
    localparam int BW      = $clog2(BUCKETS);
    localparam int EW      = $clog2(ENTRIES);
    localparam int LW      = $clog2(ENTRIES + 1);
    localparam int MAXN    = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
    localparam int SW      = $clog2(MAXN);
    localparam int DW      = 192;

    localparam logic [63:0]   HASH_MUL = 64'd31415926525;
    localparam logic [LW-1:0] NIL      = LW'(ENTRIES);

    localparam logic [1:0] CMD_SET    = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [63:0] key_a;
        logic signed [63:0] key_b;
        logic [63:0]        value;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [63:0] value_out;
        logic        status;
        logic [8:0]  held_total;
    } rsp_t;

endpackage

// ===== rtl/tkchm_ram.sv =====
// ---------------------------------------------------------------------------
// tkchm_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module tkchm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/two_key_chained_hash_map.sv =====
// A request steps through hash, bucket-head read, one chain step per link visited and
// finish; remove adds an unlink step per unlinked entry, a set that allocates adds the
// ST_ALLOC and ST_ALLOC2 steps, and clear sweeps both tables. One request at a time: the
// next is accepted as rsp_valid rises; a response held by rsp_ready stalls the input.
// Reset: a sweep empties the bucket table and rebuilds the free list; no request is
// accepted until it ends.
// ---------------------------------------------------------------------------
// two_key_chained_hash_map
// Chained hash map from a pair of 64-bit keys to a 64-bit value.
// ---------------------------------------------------------------------------
`include "two_key_chained_hash_map_defines.svh"

module two_key_chained_hash_map
    import tkchm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_HASH   = 4'd1;
    localparam logic [3:0] ST_HEAD   = 4'd2;
    localparam logic [3:0] ST_ENT    = 4'd3;
    localparam logic [3:0] ST_UNLINK = 4'd4;
    localparam logic [3:0] ST_ALLOC  = 4'd5;
    localparam logic [3:0] ST_ALLOC2 = 4'd6;
    localparam logic [3:0] ST_FINISH = 4'd7;
    localparam logic [3:0] ST_SWEEP  = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic [63:0]   ka_reg, ka_next, kb_reg, kb_next, val_reg, val_next;
    logic [BW-1:0] pa_reg, pa_next, pb_reg, pb_next;
    logic [BW-1:0] bucket_reg, bucket_next;
    logic [LW-1:0] head_reg, head_next, cur_reg, cur_next;
    logic [LW-1:0] prev_reg, prev_next, nx_reg, nx_next;
    logic [LW-1:0] free_head_reg, free_head_next, count_reg, count_next;
    logic          found_reg, found_next, status_reg, status_next;
    logic [63:0]   vout_reg, vout_next;
    logic [SW-1:0] sweep_idx_reg, sweep_idx_next;
    logic          sweep_clear_reg, sweep_clear_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    logic          h_we;
    logic [BW-1:0] h_waddr, h_raddr;
    logic [LW-1:0] h_wdata, h_rdata;
    logic          n_we;
    logic [EW-1:0] n_waddr, n_raddr;
    logic [LW-1:0] n_wdata, n_rdata;
    logic          d_we;
    logic [EW-1:0] d_waddr, d_raddr;
    logic [DW-1:0] d_wdata, d_rdata;

    logic          match;
    logic [LW:0]   sweep_link;
    logic [LW+8:0] count_wide;

    tkchm_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_heads (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    tkchm_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_next (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rdata)
    );

    tkchm_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_data (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(d_raddr), .rdata(d_rdata)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign match      = (d_rdata[191:128] == ka_reg) && (d_rdata[127:64] == kb_reg);
    assign sweep_link = (LW + 1)'(sweep_idx_reg) + (LW + 1)'(1);
    assign count_wide = {9'd0, count_reg};

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        ka_next          = ka_reg;
        kb_next          = kb_reg;
        val_next         = val_reg;
        pa_next          = pa_reg;
        pb_next          = pb_reg;
        bucket_next      = bucket_reg;
        head_next        = head_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        nx_next          = nx_reg;
        free_head_next   = free_head_reg;
        count_next       = count_reg;
        found_next       = found_reg;
        status_next      = status_reg;
        vout_next        = vout_reg;
        sweep_idx_next   = sweep_idx_reg;
        sweep_clear_next = sweep_clear_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        rsp_next         = rsp_reg;

        h_we    = 1'b0;
        h_waddr = bucket_reg;
        h_wdata = NIL;
        h_raddr = bucket_reg;
        n_we    = 1'b0;
        n_waddr = cur_reg[EW-1:0];
        n_wdata = free_head_reg;
        n_raddr = cur_reg[EW-1:0];
        d_we    = 1'b0;
        d_waddr = cur_reg[EW-1:0];
        d_wdata = {ka_reg, kb_reg, val_reg};
        d_raddr = cur_reg[EW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next    = req.command;
                    ka_next     = req.key_a;
                    kb_next     = req.key_b;
                    val_next    = req.value;
                    // only the low BW bits of each product reach the bucket index
                    pa_next     = BW'(req.key_a[BW+2:3] * HASH_MUL[BW-1:0]);
                    pb_next     = BW'(req.key_b[BW+2:3] * HASH_MUL[BW-1:0]);
                    found_next  = 1'b0;
                    status_next = 1'b0;
                    vout_next   = 64'd0;
                    state_next  = ST_HASH;
                end
            end
            ST_HASH:
            begin
                bucket_next = pa_reg + pb_reg;
                h_raddr     = pa_reg + pb_reg;
                if (cmd_reg == CMD_CLEAR)
                begin
                    sweep_idx_next   = '0;
                    sweep_clear_next = 1'b1;
                    state_next       = ST_SWEEP;
                end
                else
                begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                head_next = h_rdata;
                cur_next  = h_rdata;
                prev_next = NIL;
                n_raddr   = h_rdata[EW-1:0];
                d_raddr   = h_rdata[EW-1:0];
                if (h_rdata == NIL)
                begin
                    state_next = (cmd_reg == CMD_SET) ? ST_ALLOC : ST_FINISH;
                end
                else
                begin
                    state_next = ST_ENT;
                end
            end
            ST_ENT:
            begin
                n_raddr = n_rdata[EW-1:0];
                d_raddr = n_rdata[EW-1:0];
                if (match && cmd_reg == CMD_SET)
                begin
                    d_we       = 1'b1;
                    found_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (match && cmd_reg == CMD_SEARCH)
                begin
                    found_next = 1'b1;
                    vout_next  = d_rdata[63:0];
                    state_next = ST_FINISH;
                end
                else if (match)
                begin
                    // push onto the free list now, relink the predecessor next cycle
                    n_we           = 1'b1;
                    free_head_next = cur_reg;
                    nx_next        = n_rdata;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - LW'(1);
                    end
                    state_next = ST_UNLINK;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = n_rdata;
                    if (n_rdata == NIL)
                    begin
                        state_next = (cmd_reg == CMD_SET) ? ST_ALLOC : ST_FINISH;
                    end
                end
            end
            ST_UNLINK:
            begin
                if (prev_reg == NIL)
                begin
                    h_we    = 1'b1;
                    h_wdata = nx_reg;
                end
                else
                begin
                    n_we    = 1'b1;
                    n_waddr = prev_reg[EW-1:0];
                    n_wdata = nx_reg;
                end
                cur_next   = nx_reg;
                n_raddr    = nx_reg[EW-1:0];
                d_raddr    = nx_reg[EW-1:0];
                state_next = (nx_reg == NIL) ? ST_FINISH : ST_ENT;
            end
            ST_ALLOC:
            begin
                n_raddr = free_head_reg[EW-1:0];
                if (free_head_reg == NIL)
                begin
                    status_next = 1'b1;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    state_next = ST_ALLOC2;
                end
            end
            ST_ALLOC2:
            begin
                free_head_next = n_rdata;
                d_we           = 1'b1;
                d_waddr        = free_head_reg[EW-1:0];
                n_we           = 1'b1;
                n_waddr        = free_head_reg[EW-1:0];
                n_wdata        = head_reg;
                h_we           = 1'b1;
                h_wdata        = free_head_reg;
                count_next     = count_reg + LW'(1);
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.found      = found_reg;
                    rsp_next.value_out  = vout_reg;
                    rsp_next.status     = status_reg;
                    rsp_next.held_total = count_wide[8:0];
                    rsp_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                h_we    = ({1'b0, sweep_idx_reg} < (SW + 1)'(BUCKETS));
                h_waddr = sweep_idx_reg[BW-1:0];
                h_wdata = NIL;
                n_we    = ({1'b0, sweep_idx_reg} < (SW + 1)'(ENTRIES));
                n_waddr = sweep_idx_reg[EW-1:0];
                n_wdata = sweep_link[LW-1:0];
                if (sweep_idx_reg == SW'(MAXN - 1))
                begin
                    free_head_next = '0;
                    count_next     = '0;
                    state_next     = sweep_clear_reg ? ST_FINISH : ST_IDLE;
                end
                else
                begin
                    sweep_idx_next = sweep_idx_reg + SW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SWEEP;
            sweep_idx_reg   <= '0;
            sweep_clear_reg <= 1'b0;
            free_head_reg   <= '0;
            count_reg       <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            sweep_idx_reg   <= sweep_idx_next;
            sweep_clear_reg <= sweep_clear_next;
            free_head_reg   <= free_head_next;
            count_reg       <= count_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        ka_reg     <= ka_next;
        kb_reg     <= kb_next;
        val_reg    <= val_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        bucket_reg <= bucket_next;
        head_reg   <= head_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        nx_reg     <= nx_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        vout_reg   <= vout_next;
        rsp_reg    <= rsp_next;
    end

    `TKCHM_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= NIL)
    `TKCHM_ASSERT_IMP(a_full_pool, clk, rst_n, state_reg == ST_IDLE && free_head_reg == NIL, count_reg == NIL)
    `TKCHM_ASSERT_IMP(a_fail_only_full, clk, rst_n, state_reg == ST_FINISH && status_reg, free_head_reg == NIL)
    `TKCHM_ASSERT_NXT(a_accept_hash, clk, rst_n, req_valid && req_ready, state_reg == ST_HASH)

endmodule

// ===== tb/tkchm_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tkchm_checker
// Watches both channels of the hash map, keeps a shadow copy of the
// chained table, and compares each response with the expected one in order.
// ---------------------------------------------------------------------------
module tkchm_checker
    import tkchm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  req_t        req,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  rsp_t        rsp,
    output int          fail_count,
    output int          pending
);

    logic [LW-1:0]  heads [BUCKETS];
    logic [63:0]    ent_ka [ENTRIES];
    logic [63:0]    ent_kb [ENTRIES];
    logic [63:0]    ent_val [ENTRIES];
    logic [LW-1:0]  ent_next [ENTRIES];
    logic [LW-1:0]  free_head;
    int             held;
    rsp_t           expected_rsp [$];

    function automatic logic [BW-1:0] chain_index(logic [63:0] ka, logic [63:0] kb);
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        logic [63:0]        sum;
        begin
            // shift in a signed context of its own so the sign bit is kept
            sa = $signed(ka) >>> 3;
            sb = $signed(kb) >>> 3;
            sum = sa * HASH_MUL + sb * HASH_MUL;
            return sum[BW-1:0];
        end
    endfunction

    task automatic empty_table();
        begin
            for (int i = 0; i < BUCKETS; i++)
                heads[i] = NIL;
            for (int i = 0; i < ENTRIES; i++)
                ent_next[i] = LW'(i + 1);
            free_head = '0;
            held = 0;
        end
    endtask

    task automatic map_apply(input req_t r, output rsp_t res);
        logic [BW-1:0]  b;
        logic [LW-1:0]  e;
        logic [LW-1:0]  prev;
        logic [LW-1:0]  nx;
        int             steps;
        begin
            res = '0;
            b = chain_index(r.key_a, r.key_b);
            case (r.command)
                CMD_SET, CMD_SEARCH:
                begin
                    e = heads[b];
                    steps = 0;
                    while (e < NIL && steps < ENTRIES && !res.found)
                    begin
                        if (ent_ka[e] == r.key_a && ent_kb[e] == r.key_b)
                        begin
                            res.found = 1'b1;
                            if (r.command == CMD_SET)
                                ent_val[e] = r.value;
                            else
                                res.value_out = ent_val[e];
                        end
                        else
                            e = ent_next[e];
                        steps++;
                    end
                    if (r.command == CMD_SET && !res.found)
                    begin
                        if (free_head >= NIL)
                            res.status = 1'b1;
                        else
                        begin
                            e = free_head;
                            free_head = ent_next[e];
                            ent_ka[e] = r.key_a;
                            ent_kb[e] = r.key_b;
                            ent_val[e] = r.value;
                            ent_next[e] = heads[b];
                            heads[b] = e;
                            held++;
                        end
                    end
                end
                CMD_REMOVE:
                begin
                    prev = NIL;
                    e = heads[b];
                    steps = 0;
                    while (e < NIL && steps < ENTRIES)
                    begin
                        nx = ent_next[e];
                        if (ent_ka[e] == r.key_a && ent_kb[e] == r.key_b)
                        begin
                            if (prev < NIL)
                                ent_next[prev] = nx;
                            else
                                heads[b] = nx;
                            ent_next[e] = free_head;
                            free_head = e;
                            if (held > 0)
                                held--;
                        end
                        else
                            prev = e;
                        e = nx;
                        steps++;
                    end
                end
                default:
                    empty_table();
            endcase
            res.held_total = held[8:0];
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
        empty_table();
    end

    always @(posedge clk)
    begin
        rsp_t want;
        rsp_t got;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                got = rsp;
                if (expected_rsp.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected response: %p", got);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (got.found !== want.found || got.value_out !== want.value_out ||
                        got.status !== want.status || got.held_total !== want.held_total)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected found=%0d value=%h status=%0d ",
                                      "count=%0d, got found=%0d value=%h status=%0d count=%0d"},
                                     want.found, want.value_out, want.status, want.held_total,
                                     got.found, got.value_out, got.status, got.held_total);
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                map_apply(req, want);
                expected_rsp.push_back(want);
            end
            pending = expected_rsp.size();
        end
    end

endmodule

// ===== tb/tb_two_key_chained_hash_map.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_two_key_chained_hash_map
// Drives set, search, remove and clear requests over key pairs that share
// chains, with random idling and back-pressure; the checker scores responses.
// ---------------------------------------------------------------------------
module tb_two_key_chained_hash_map;
    import tkchm_pkg::*;

    localparam int  RANDOM_REQS = 1650;
    localparam int  GROUPS      = 48;
    localparam int  CYCLE_LIMIT = 3000000;

    logic   clk;
    logic   rst_n;
    logic   req_valid;
    logic   req_ready;
    req_t   req;
    logic   rsp_valid;
    logic   rsp_ready;
    rsp_t   rsp;
    logic   req_taken;
    logic   steady;
    int     fail_count;
    int     pending;
    int     cycles;
    logic [63:0] group_ka [GROUPS];
    logic [63:0] group_kb [GROUPS];

    two_key_chained_hash_map dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    tkchm_checker scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
        req_taken <= req_valid && req_ready;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** two_key_chained_hash_map: FAILED **");
            $finish;
        end
    end

    // Response side: random stalls, plus one long hold-off while requests pile up.
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        repeat (3000)
        begin
            @(negedge clk);
            rsp_ready = steady || ($urandom_range(99) >= 38);
        end
        @(negedge clk);
        rsp_ready = 1'b0;
        repeat (600)
            @(negedge clk);
        forever
        begin
            @(negedge clk);
            rsp_ready = steady || ($urandom_range(99) >= 38);
        end
    end

    task automatic send(input logic [1:0] cmd, input logic [63:0] ka,
                        input logic [63:0] kb, input logic [63:0] val);
        begin
            while (!steady && $urandom_range(99) < 38)
            begin
                req_valid = 1'b0;
                @(negedge clk);
            end
            req_valid = 1'b1;
            req.command = cmd;
            req.key_a = ka;
            req.key_b = kb;
            req.value = val;
            do
                @(negedge clk);
            while (!req_taken);
        end
    endtask

    // Members of a group differ in the low three key bits, so they share a chain.
    function automatic logic [63:0] member_a(int g, int m);
        return {group_ka[g][63:3], 3'(m)};
    endfunction

    initial
    begin
        logic [1:0] cmd;
        int         g;
        int         m;
        int         pick;
        int         wait_cycles;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cycles = 0;
        steady = 1'b0;
        group_ka[0] = 64'h8000_0000_0000_0000;
        group_kb[0] = 64'h7fff_ffff_ffff_ffff;
        group_ka[1] = 64'h7fff_ffff_ffff_fff8;
        group_kb[1] = 64'h8000_0000_0000_0000;
        group_ka[2] = '0;
        group_kb[2] = '1;
        for (int i = 3; i < GROUPS; i++)
        begin
            group_ka[i] = {$urandom, $urandom};
            group_kb[i] = {$urandom, $urandom};
        end
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, overwrite, chain collisions, removes and clear
        send(CMD_SEARCH, member_a(0, 0), group_kb[0], '1);
        send(CMD_SET, member_a(0, 0), group_kb[0], '1);
        send(CMD_SET, member_a(0, 7), group_kb[0], '0);
        send(CMD_SET, member_a(1, 7), group_kb[1], 64'h5555_aaaa_5555_aaaa);
        send(CMD_SET, member_a(2, 0), group_kb[2], 64'haaaa_5555_aaaa_5555);
        send(CMD_SEARCH, member_a(0, 0), group_kb[0], '0);
        send(CMD_SEARCH, member_a(0, 7), group_kb[0], '0);
        send(CMD_SET, member_a(0, 0), group_kb[0], 64'h0123_4567_89ab_cdef);
        send(CMD_SEARCH, member_a(0, 0), group_kb[0], '0);
        send(CMD_REMOVE, member_a(0, 3), group_kb[0], '0);
        send(CMD_REMOVE, member_a(0, 7), group_kb[0], '0);
        send(CMD_SEARCH, member_a(0, 7), group_kb[0], '0);
        send(CMD_SEARCH, member_a(0, 0), group_kb[0], '0);
        send(CMD_REMOVE, member_a(0, 0), group_kb[0], '0);
        send(CMD_SEARCH, member_a(1, 7), group_kb[1], '0);
        send(CMD_CLEAR, '0, '0, '0);
        send(CMD_SEARCH, member_a(2, 0), group_kb[2], '0);

        // fill the pool past its size to reach the full case
        steady = 1'b1;
        for (int i = 0; i < 262; i++)
            send(CMD_SET, member_a(i / 8 + 3, i % 8), group_kb[i / 8 + 3], {$urandom, $urandom});
        send(CMD_SEARCH, member_a(3, 0), group_kb[3], '0);
        send(CMD_REMOVE, member_a(3, 0), group_kb[3], '0);
        send(CMD_SET, member_a(40, 5), group_kb[40], '1);
        send(CMD_CLEAR, '0, '0, '0);
        steady = 1'b0;

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (n == 700)
            begin
                // hold until everything in flight has drained
                req_valid = 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
            steady = (n >= 1000 && n < 1250);
            pick = $urandom_range(99);
            cmd = (pick < 40) ? CMD_SET : (pick < 70) ? CMD_SEARCH :
                  (pick < 98) ? CMD_REMOVE : CMD_CLEAR;
            g = $urandom_range(GROUPS - 1);
            m = $urandom_range(7);
            if ($urandom_range(19) == 0)
                send(cmd, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
            else
                send(cmd, member_a(g, m), group_kb[g], {$urandom, $urandom});
        end
        req_valid = 1'b0;

        wait_cycles = 0;
        while (pending != 0)
            @(negedge clk);
        while (wait_cycles < 1200)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        if (fail_count == 0)
            $display("** two_key_chained_hash_map: PASSED **");
        else
            $display("** two_key_chained_hash_map: FAILED **");
        $finish;
    end

endmodule
